// ----- sv/ppm_pkg.sv -----
// shared types and constants for the binary image header parser
`timescale 1ns / 1ps
`default_nettype none

package ppm_pkg;

  // width of the result number fields
  localparam int unsigned OutBits = 16;

  // characters of interest
  localparam logic [7:0] CharP     = 8'h50;
  localparam logic [7:0] CharSix   = 8'h36;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // only accepted maximum sample value
  localparam int unsigned MaxvalOk = 255;

  // result codes
  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_MAGIC  = 3'd1,
    ERR_EARLY  = 3'd2,
    ERR_NUMBER = 3'd3,
    ERR_ZERO   = 3'd4,
    ERR_MAXVAL = 3'd5
  } err_e;

  // which header token is expected
  typedef enum logic [1:0] {
    TOK_MAGIC  = 2'd0,
    TOK_WIDTH  = 2'd1,
    TOK_HEIGHT = 2'd2,
    TOK_MAXVAL = 2'd3
  } tok_e;

  // progress through the magic token
  typedef enum logic [1:0] {
    MAG_NONE = 2'd0,
    MAG_P    = 2'd1,
    MAG_P6   = 2'd2
  } mag_e;

  // one result item from the parser core
  typedef struct packed {
    logic                 header_ok;
    err_e                 error_code;
    logic [OutBits-1:0]   image_width;
    logic [OutBits-1:0]   image_height;
    logic [OutBits-1:0]   max_value;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/ppm_p6_header_parser.sv -----
// binary image header parser: input register, parser step, result register
// a result is registered as the byte that causes it leaves the input register
// throughput: one byte per cycle when no result waits; one parser update per byte
// a waiting result stalls the parser step; one more byte is still taken in
// reset clears the parser to expect the magic token and empties both registers
`timescale 1ns / 1ps
`default_nettype none

module ppm_p6_header_parser #(
  parameter int unsigned DIM_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             header_ok_o,
  output logic [2:0]       error_code_o,
  output logic [15:0]      image_width_o,
  output logic [15:0]      image_height_o,
  output logic [15:0]      max_value_o
);
  import ppm_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_vld_q, out_vld_d;
  res_t       out_q;
  logic       advance;
  logic       take;
  logic       res_valid;
  res_t       res;

  // handshake
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign take       = in_valid_i && in_ready_o;
  assign in_vld_d   = take || (in_vld_q && !advance);
  assign out_vld_d  = (advance && res_valid) || (out_vld_q && !out_ready_i);

  // parser core
  ppm_core #(
    .DIM_BITS(DIM_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .data_byte_i(in_byte_q),
    .last_byte_i(in_last_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // input item register
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign header_ok_o    = out_q.header_ok;
  assign error_code_o   = out_q.error_code;
  assign image_width_o  = out_q.image_width;
  assign image_height_o = out_q.image_height;
  assign max_value_o    = out_q.max_value;

endmodule

`default_nettype wire

// ----- sv/ppm_core.sv -----
// parser state and the per-byte header step
`timescale 1ns / 1ps
`default_nettype none

module ppm_core #(
  parameter int unsigned DIM_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             res_valid_o,
  output ppm_pkg::res_t    res_o
);
  import ppm_pkg::*;

  localparam int unsigned ProdBits = DIM_BITS + 4;

  tok_e                tok_q, tok_d;
  mag_e                mag_q, mag_d;
  logic                in_tok_q, in_tok_d;
  logic                in_com_q, in_com_d;
  logic                dd_q, dd_d;
  logic                ni_q, ni_d;
  logic                fin_q, fin_d;
  logic [DIM_BITS-1:0] nv_q, nv_d;
  logic [DIM_BITS-1:0] hw_q, hw_d;
  logic [DIM_BITS-1:0] hh_q, hh_d;

  logic                is_space;
  logic                is_digit;
  logic [3:0]          digit;
  logic [ProdBits-1:0] prod;
  logic                hit;
  logic                do_end;
  err_e                code;
  logic [DIM_BITS-1:0] maxv;
  res_t                res;

  // character classes
  assign is_space = (data_byte_i inside {CharSpace, [CharTab:CharCr]});
  assign is_digit = (data_byte_i inside {[CharZero:CharNine]});
  assign digit    = 4'(data_byte_i - CharZero);

  // one byte of the header walk
  always_comb begin
    tok_d    = tok_q;
    mag_d    = mag_q;
    in_tok_d = in_tok_q;
    in_com_d = in_com_q;
    dd_d     = dd_q;
    ni_d     = ni_q;
    fin_d    = fin_q;
    nv_d     = nv_q;
    hw_d     = hw_q;
    hh_d     = hh_q;
    hit      = 1'b0;
    do_end   = 1'b0;
    code     = ERR_NONE;
    prod     = '0;
    maxv     = '0;
    res      = '0;

    if (!fin_q) begin
      // comment, whitespace or token character
      if (in_com_q) begin
        if (data_byte_i == CharLf) begin
          in_com_d = 1'b0;
        end
      end else if (in_tok_q && is_space) begin
        do_end = 1'b1;
      end else if (!in_tok_q && data_byte_i == CharHash) begin
        in_com_d = 1'b1;
      end else if (in_tok_q || !is_space) begin
        if (!in_tok_q) begin
          in_tok_d = 1'b1;
          nv_d     = '0;
          dd_d     = 1'b0;
          ni_d     = 1'b0;
        end
        if (tok_q == TOK_MAGIC) begin
          if (mag_q == MAG_NONE && data_byte_i == CharP) begin
            mag_d = MAG_P;
          end else if (mag_q == MAG_P && data_byte_i == CharSix) begin
            mag_d = MAG_P6;
          end else begin
            hit  = 1'b1;
            code = ERR_MAGIC;
          end
        end else if (!dd_d) begin
          if (is_digit) begin
            prod = (ProdBits'(nv_d) << 3) + (ProdBits'(nv_d) << 1) + ProdBits'(digit);
            if (|prod[ProdBits-1:DIM_BITS]) begin
              ni_d = 1'b1;
            end else begin
              nv_d = prod[DIM_BITS-1:0];
            end
          end else if (!in_tok_q) begin
            hit  = 1'b1;
            code = ERR_NUMBER;
          end else begin
            dd_d = 1'b1;
          end
        end
      end

      // end of stream closes an open token
      if (!hit && last_byte_i && in_tok_d) begin
        do_end = 1'b1;
      end

      // token end
      if (do_end) begin
        in_tok_d = 1'b0;
        case (tok_d)
          TOK_MAGIC: begin
            if (mag_d != MAG_P6) begin
              hit  = 1'b1;
              code = ERR_MAGIC;
            end else begin
              tok_d = TOK_WIDTH;
            end
          end
          TOK_WIDTH: begin
            if (ni_d) begin
              hit  = 1'b1;
              code = ERR_NUMBER;
            end else begin
              hw_d  = nv_d;
              tok_d = TOK_HEIGHT;
            end
          end
          TOK_HEIGHT: begin
            if (ni_d) begin
              hit  = 1'b1;
              code = ERR_NUMBER;
            end else begin
              hh_d  = nv_d;
              tok_d = TOK_MAXVAL;
            end
          end
          default: begin
            hit = 1'b1;
            if (ni_d) begin
              code = ERR_NUMBER;
            end else if (hw_d == '0 || hh_d == '0) begin
              code = ERR_ZERO;
            end else if (nv_d != DIM_BITS'(MaxvalOk)) begin
              code = ERR_MAXVAL;
            end else begin
              code = ERR_NONE;
            end
          end
        endcase
      end

      // stream ended with no verdict
      if (!hit && last_byte_i) begin
        hit  = 1'b1;
        code = ERR_EARLY;
      end

      // result fields from the updated state
      if (code == ERR_NONE || code == ERR_ZERO || code == ERR_MAXVAL) begin
        maxv = nv_d;
      end
      res.header_ok    = (code == ERR_NONE);
      res.error_code   = code;
      res.image_width  = OutBits'(hw_d);
      res.image_height = OutBits'(hh_d);
      res.max_value    = OutBits'(maxv);

      if (hit && !last_byte_i) begin
        fin_d = 1'b1;
      end
    end

    // last byte returns the parser to its idle state
    if (last_byte_i && (fin_q || hit)) begin
      tok_d    = TOK_MAGIC;
      mag_d    = MAG_NONE;
      in_tok_d = 1'b0;
      in_com_d = 1'b0;
      dd_d     = 1'b0;
      ni_d     = 1'b0;
      fin_d    = 1'b0;
      nv_d     = '0;
      hw_d     = '0;
      hh_d     = '0;
    end
  end

  assign res_valid_o = step_i && hit;
  assign res_o       = res;

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= TOK_MAGIC;
      mag_q    <= MAG_NONE;
      in_tok_q <= 1'b0;
      in_com_q <= 1'b0;
      dd_q     <= 1'b0;
      ni_q     <= 1'b0;
      fin_q    <= 1'b0;
      nv_q     <= '0;
      hw_q     <= '0;
      hh_q     <= '0;
    end else if (step_i) begin
      tok_q    <= tok_d;
      mag_q    <= mag_d;
      in_tok_q <= in_tok_d;
      in_com_q <= in_com_d;
      dd_q     <= dd_d;
      ni_q     <= ni_d;
      fin_q    <= fin_d;
      nv_q     <= nv_d;
      hw_q     <= hw_d;
      hh_q     <= hh_d;
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb_ppm_p6_header_parser.sv -----
// self-checking testbench for the binary image header parser
`timescale 1ns / 1ps

module tb_ppm_p6_header_parser;
  import ppm_pkg::*;

  // whitespace bytes that the package does not name
  localparam logic [7:0] CharVt = 8'h0b;
  localparam logic [7:0] CharFf = 8'h0c;

  localparam int unsigned ItemTarget = 1100;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongHold = 300;
  localparam int unsigned DirRows = 19;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        header_ok_o;
  logic [2:0]  error_code_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;
  logic [15:0] max_value_o;

  ppm_p6_header_parser #(
    .DIM_BITS(16)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .header_ok_o   (header_ok_o),
    .error_code_o  (error_code_o),
    .image_width_o (image_width_o),
    .image_height_o(image_height_o),
    .max_value_o   (max_value_o)
  );

  // clock
  always #6 clk_i = ~clk_i;

  // parser state of the predictor
  tok_e        hdr_tok;
  mag_e        hdr_mag;
  bit          in_tok;
  bit          in_cmt;
  bit          digits_end;
  bit          num_over;
  bit          hdr_done;
  logic [15:0] num_val;
  logic [15:0] held_w;
  logic [15:0] held_h;

  // bench bookkeeping
  res_t        pending_headers[$];
  logic [7:0]  frame_bytes[$];
  bit          use_typed;
  res_t        typed_want;
  bit          burst_mode;
  bit          long_hold_req;
  int          mismatch_count;
  int          result_count;
  int          parsed_bytes;
  int          sent_count;
  int          frame_count;
  int          cycle_count;
  int          code_count[6];

  // directed frames; typed rows carry their expected header
  string dir_text[DirRows] = '{
    "P6 65535 65535 255 ", "P5", "P", "P6", "P6 -3", "P6 +7 2 255\n",
    "P6 65536 1 255 ", "P6 0 5 255\n", "P6 1 1 254\n", "P6 \377",
    "P7 1 2 255\n", "P66 1 1 255 ", "# note\nP6 #c\n 12#z 3\015255\014",
    "P6\t0255x\0131 0255 ", "P6 7 9", "P6 3 4 255", "P6 1 1 1\n",
    "P6 4 3 65536\n", "P6 9 # rest\n"
  };
  bit dir_typed[DirRows] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
                             0, 0, 0, 0, 0, 0, 0};
  res_t dir_want[DirRows] = '{
    res_t'{1'b1, ERR_NONE, 16'd65535, 16'd65535, 16'd255},
    res_t'{1'b0, ERR_MAGIC, 16'd0, 16'd0, 16'd0},
    res_t'{1'b0, ERR_MAGIC, 16'd0, 16'd0, 16'd0},
    res_t'{1'b0, ERR_EARLY, 16'd0, 16'd0, 16'd0},
    res_t'{1'b0, ERR_NUMBER, 16'd0, 16'd0, 16'd0},
    res_t'{1'b0, ERR_NUMBER, 16'd0, 16'd0, 16'd0},
    res_t'{1'b0, ERR_NUMBER, 16'd0, 16'd0, 16'd0},
    res_t'{1'b0, ERR_ZERO, 16'd0, 16'd5, 16'd255},
    res_t'{1'b0, ERR_MAXVAL, 16'd1, 16'd1, 16'd254},
    res_t'{1'b0, ERR_NUMBER, 16'd0, 16'd0, 16'd0},
    res_t'{1'b0, ERR_MAGIC, 16'd0, 16'd0, 16'd0},
    res_t'{1'b0, ERR_MAGIC, 16'd0, 16'd0, 16'd0},
    '0, '0, '0, '0, '0, '0, '0
  };

  // back to the state after reset
  function automatic void clear_parser();
    hdr_tok = TOK_MAGIC;
    hdr_mag = MAG_NONE;
    in_tok = 1'b0;
    in_cmt = 1'b0;
    digits_end = 1'b0;
    num_over = 1'b0;
    hdr_done = 1'b0;
    num_val = '0;
    held_w = '0;
    held_h = '0;
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == CharSpace || (b >= CharTab && b <= CharCr);
  endfunction

  // one character inside a token; returns 1 when it ends the header
  function automatic bit take_char(input logic [7:0] b, input bit lead, output err_e code);
    logic [31:0] grown;
    code = ERR_NONE;
    if (hdr_tok == TOK_MAGIC) begin
      if (hdr_mag == MAG_NONE && b == CharP) begin
        hdr_mag = MAG_P;
        return 1'b0;
      end
      if (hdr_mag == MAG_P && b == CharSix) begin
        hdr_mag = MAG_P6;
        return 1'b0;
      end
      code = ERR_MAGIC;
      return 1'b1;
    end
    if (digits_end) return 1'b0;
    if (b >= CharZero && b <= CharNine) begin
      grown = 32'(num_val) * 32'd10 + 32'(b - CharZero);
      // an oversized number keeps its last fitting value
      if (grown > 32'h0000_ffff) num_over = 1'b1;
      else num_val = grown[15:0];
      return 1'b0;
    end
    if (lead) begin
      code = ERR_NUMBER;
      return 1'b1;
    end
    digits_end = 1'b1;
    return 1'b0;
  endfunction

  // close the current token
  function automatic bit end_token(output err_e code);
    code = ERR_NONE;
    in_tok = 1'b0;
    if (hdr_tok == TOK_MAGIC) begin
      if (hdr_mag != MAG_P6) begin
        code = ERR_MAGIC;
        return 1'b1;
      end
      hdr_tok = TOK_WIDTH;
      return 1'b0;
    end
    if (num_over) begin
      code = ERR_NUMBER;
      return 1'b1;
    end
    if (hdr_tok == TOK_WIDTH) begin
      held_w = num_val;
      hdr_tok = TOK_HEIGHT;
      return 1'b0;
    end
    if (hdr_tok == TOK_HEIGHT) begin
      held_h = num_val;
      hdr_tok = TOK_MAXVAL;
      return 1'b0;
    end
    // zero size is checked before the maximum value
    if (held_w == '0 || held_h == '0) code = ERR_ZERO;
    else if (num_val != 16'(MaxvalOk)) code = ERR_MAXVAL;
    return 1'b1;
  endfunction

  // predicted header for one accepted byte; returns 1 when a result is due
  function automatic bit parse_byte(input logic [7:0] b, input bit lst, output res_t hdr,
                                    output bit ignored);
    err_e code;
    bit   fired;
    code = ERR_NONE;
    fired = 1'b0;
    hdr = '0;
    ignored = 1'b0;
    // after a result everything up to the end of the stream is dropped
    if (hdr_done) begin
      ignored = 1'b1;
      if (lst) clear_parser();
      return 1'b0;
    end
    if (in_cmt) begin
      if (b == CharLf) in_cmt = 1'b0;
    end else if (in_tok) begin
      if (is_blank(b)) fired = end_token(code);
      else fired = take_char(b, 1'b0, code);
    end else if (b == CharHash) begin
      in_cmt = 1'b1;
    end else if (!is_blank(b)) begin
      in_tok = 1'b1;
      num_val = '0;
      digits_end = 1'b0;
      num_over = 1'b0;
      fired = take_char(b, 1'b1, code);
    end
    // end of stream closes an open token, else the header is short
    if (!fired && lst) begin
      if (in_tok) fired = end_token(code);
      if (!fired) begin
        fired = 1'b1;
        code = ERR_EARLY;
      end
    end
    if (!fired) return 1'b0;
    hdr.header_ok = (code == ERR_NONE);
    hdr.error_code = code;
    hdr.image_width = held_w;
    hdr.image_height = held_h;
    hdr.max_value = (code == ERR_NONE || code == ERR_ZERO || code == ERR_MAXVAL) ? num_val : '0;
    if (lst) clear_parser();
    else hdr_done = 1'b1;
    return 1'b1;
  endfunction

  function automatic int draw_wait();
    return burst_mode ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CharSpace;
      1: return CharTab;
      2: return CharLf;
      3: return CharVt;
      4: return CharFf;
      default: return CharCr;
    endcase
  endfunction

  // append one byte to the stream being built
  task automatic add_byte(input logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endtask

  task automatic push_text(input string s);
    for (int k = 0; k < s.len(); k++) add_byte(s[k]);
  endtask

  // whitespace between tokens, now and then with a comment
  task automatic push_gap();
    logic [7:0] c;
    repeat ($urandom_range(1, 2)) add_byte(pick_blank());
    if ($urandom_range(0, 5) == 0) begin
      add_byte(CharHash);
      repeat ($urandom_range(0, 6)) begin
        c = 8'($urandom_range(0, 255));
        add_byte(c == CharLf ? CharSpace : c);
      end
      add_byte(CharLf);
      if ($urandom_range(0, 1) == 1) add_byte(pick_blank());
    end
  endtask

  // one number token: mostly plausible, sometimes signed, oversized or junk
  task automatic push_number(input bit for_maxval);
    int unsigned pick;
    int unsigned v;
    pick = $urandom_range(0, 15);
    v = $urandom_range(1, 600);
    if (for_maxval && pick < 10) begin
      v = MaxvalOk;
    end else begin
      case (pick)
        0: v = 0;
        1: v = 65535;
        2: v = $urandom_range(65536, 999999);
        3: begin
          push_text($urandom_range(0, 1) == 1 ? "-" : "+");
          v = $urandom_range(0, 99);
        end
        4: begin
          add_byte(8'(8'h61 + $urandom_range(0, 25)));
          return;
        end
        5: v = 254 + $urandom_range(0, 2);
        default: ;
      endcase
    end
    if ($urandom_range(0, 7) == 0) push_text("0");
    push_text($sformatf("%0d", v));
    // trailing characters after the digits are ignored by the parser
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: push_text("x");
        1: push_text("#");
        2: push_text(".");
        default: add_byte(8'($urandom_range(128, 255)));
      endcase
    end
  endtask

  // random stream: mostly well formed headers, some broken ones and noise
  task automatic build_frame();
    int kind;
    int keep;
    frame_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      if ($urandom_range(0, 3) == 0) push_gap();
      case ($urandom_range(0, 11))
        0: push_text("P");
        1: push_text("P66");
        2: add_byte(8'($urandom_range(0, 255)));
        default: push_text("P6");
      endcase
      push_gap();
      push_number(1'b0);
      push_gap();
      push_number(1'b0);
      push_gap();
      push_number(1'b1);
      add_byte(pick_blank());
      // a few pixel bytes after the header
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) begin
        keep = $urandom_range(1, frame_bytes.size());
        while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      end
    end else if (kind == 7) begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      push_text("P6");
      push_gap();
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // offer one item and predict once it is taken
  task automatic send_item(input logic [7:0] b, input bit lst);
    int   gap;
    res_t hdr;
    bit   ignored;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    if (parse_byte(b, lst, hdr, ignored))
      pending_headers.insert(pending_headers.size(), use_typed ? typed_want : hdr);
    if (!ignored) parsed_bytes++;
    sent_count++;
  endtask

  task automatic send_frame();
    for (int k = 0; k < frame_bytes.size(); k++) send_item(frame_bytes[k], k == frame_bytes.size() - 1);
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatch_count < 100) $display("mismatch at result %0d: %s", result_count, what);
    mismatch_count++;
  endtask

  // compare one taken result with the oldest expected header
  task automatic check_header();
    res_t want;
    if (pending_headers.size() == 0) begin
      flag_mismatch($sformatf("result with nothing expected, code %0d", error_code_o));
      return;
    end
    want = pending_headers.pop_front();
    result_count++;
    code_count[want.error_code]++;
    if (header_ok_o !== want.header_ok)
      flag_mismatch($sformatf("header_ok %b, want %b", header_ok_o, want.header_ok));
    if (error_code_o !== want.error_code)
      flag_mismatch($sformatf("error_code %0d, want %0d", error_code_o, want.error_code));
    if (image_width_o !== want.image_width)
      flag_mismatch($sformatf("image_width %0d, want %0d", image_width_o, want.image_width));
    if (image_height_o !== want.image_height)
      flag_mismatch($sformatf("image_height %0d, want %0d", image_height_o, want.image_height));
    if (max_value_o !== want.max_value)
      flag_mismatch($sformatf("max_value %0d, want %0d", max_value_o, want.max_value));
  endtask

  // result side: random stalls per item, one long hold on request
  initial begin
    int stall;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        stall = LongHold;
        long_hold_req = 1'b0;
      end else begin
        stall = draw_wait();
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_header();
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d headers outstanding", cycle_count,
               pending_headers.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // reset, directed frames, random frames, drain
  initial begin
    clear_parser();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      burst_mode = (r % 3 == 0);
      use_typed = dir_typed[r];
      typed_want = dir_want[r];
      frame_bytes.delete();
      push_text(dir_text[r]);
      send_frame();
      frame_count++;
    end
    use_typed = 1'b0;

    while (sent_count < ItemTarget) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      // long receiver hold while bytes keep coming
      if (frame_count % 23 == 5) long_hold_req = 1'b1;
      // sender stands back until every header is out
      if (frame_count % 31 == 7) begin
        in_valid_i <= 1'b0;
        while (pending_headers.size() != 0) @(posedge clk_i);
      end
      build_frame();
      send_frame();
      frame_count++;
    end
    in_valid_i <= 1'b0;

    while (pending_headers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d streams, %0d bytes sent, %0d parsed, %0d header results, %0d mismatches",
             frame_count, sent_count, parsed_bytes, result_count, mismatch_count);
    $display("results: ok %0d, magic %0d, early end %0d, number %0d, zero size %0d, maxval %0d",
             code_count[ERR_NONE], code_count[ERR_MAGIC], code_count[ERR_EARLY],
             code_count[ERR_NUMBER], code_count[ERR_ZERO], code_count[ERR_MAXVAL]);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ppm_pkg.sv
sv/ppm_core.sv
sv/ppm_p6_header_parser.sv
bench/tb_ppm_p6_header_parser.sv
